FILE: hdl/pkht_pkg.sv
package pkht_pkg;

    localparam int COUNT_W = 13;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 16;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_FORGET = 3'd2;
    localparam logic [2:0] OP_RANGE  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef struct packed {
        logic [2:0]       op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] key_end;
        logic [VAL_W-1:0] value_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   value_out;
        logic [COUNT_W-1:0] live_entries;
        logic [COUNT_W-1:0] used_slots;
    } t_res;

    typedef struct packed {
        logic [1:0]       mark;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        CLS_HASH,
        CLS_RANGE,
        CLS_CLEAR,
        CLS_REJECT
    } t_cls;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_PRD,
        B_PEV,
        B_SRD,
        B_SEV,
        B_CLR
    } t_bstate;

endpackage

FILE: hdl/pkht_ram.sv
module pkht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pkht_fifo.sv
module pkht_fifo
    import pkht_pkg::*;
#(
    parameter int SLOT_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cmd              i_cmd,
    input  t_cls              i_cls,
    input  logic [SLOT_W-1:0] i_home,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output t_cmd              o_cmd,
    output t_cls              o_cls,
    output logic [SLOT_W-1:0] o_home
);

    t_cmd              r_cmd  [2];
    t_cls              r_cls  [2];
    logic [SLOT_W-1:0] r_home [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_cmd[r_wp]  <= i_cmd;
            r_cls[r_wp]  <= i_cls;
            r_home[r_wp] <= i_home;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_cmd[r_rp];
    assign o_cls   = r_cls[r_rp];
    assign o_home  = r_home[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

endmodule

FILE: hdl/pkht_front.sv
module pkht_front
    import pkht_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096,
    parameter int SLOT_W      = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_cmd              i_cmd,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_push,
    output t_cmd              o_cmd,
    output t_cls              o_cls,
    output logic [SLOT_W-1:0] o_home
);

    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [32:0] RECIP = 33'((64'd1 << (32 + SLOT_W)) / TABLE_SLOTS);

    t_fstate           r_state, n_state;
    t_cmd              r_cmd;
    t_cls              r_cls, n_cls;
    logic [63:0]       r_x, n_x;
    logic [63:0]       r_acc, n_acc;
    logic [1:0]        r_step, n_step;
    logic              r_pass, n_pass;
    logic [31:0]       r_hash, n_hash;
    logic [31:0]       r_q, n_q;
    logic [SLOT_W-1:0] r_home, n_home;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, mix;
    logic [64:0] q_prod;
    logic [63:0] q_t;
    logic [32:0] rem_raw;
    logic        accept;
    logic        mul_last;
    logic        mod_last;

    assign accept = i_start && (r_state == F_IDLE);
    assign mul_last = (r_step == 2'd2) && r_pass;
    assign mod_last = (r_step == 2'd1);

    // Low 64 bits of a 64x64 product from three 32x32 partials, one a cycle.
    always_comb begin
        logic [63:0] c;
        c = r_pass ? MIX_C2 : MIX_C1;
        case (r_step)
            2'd0:    begin mul_a = r_x[31:0];  mul_b = c[31:0];  end
            2'd1:    begin mul_a = r_x[31:0];  mul_b = c[63:32]; end
            default: begin mul_a = r_x[63:32]; mul_b = c[31:0];  end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign mix     = r_acc + {prod[31:0], 32'd0};
    assign q_prod  = {33'd0, r_hash} * {32'd0, RECIP};
    assign q_t     = {32'd0, r_q} * 64'(TABLE_SLOTS);
    assign rem_raw = {1'b0, r_hash} - q_t[32:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = (n_cls == CLS_HASH) ? F_MUL : F_PUSH;
                end
            end
            F_MUL: begin
                if (mul_last) begin
                    n_state = IS_POW2 ? F_PUSH : F_MOD;
                end
            end
            F_MOD: begin
                if (mod_last) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_cls  = r_cls;
        n_x    = r_x;
        n_acc  = r_acc;
        n_step = r_step;
        n_pass = r_pass;
        n_hash = r_hash;
        n_q    = r_q;
        n_home = r_home;
        unique case (r_state)
            F_IDLE: begin
                if (((i_cmd.op == OP_INSERT) || (i_cmd.op == OP_LOOKUP)
                     || (i_cmd.op == OP_FORGET)) && (i_cmd.key <= 64'd1)) begin
                    n_cls = CLS_REJECT;
                end else if ((i_cmd.op == OP_INSERT) || (i_cmd.op == OP_LOOKUP)
                             || (i_cmd.op == OP_FORGET)) begin
                    n_cls = CLS_HASH;
                end else if (i_cmd.op == OP_RANGE) begin
                    n_cls = ((i_cmd.key == 64'd0) || (i_cmd.key >= i_cmd.key_end))
                            ? CLS_REJECT : CLS_RANGE;
                end else if (i_cmd.op == OP_CLEAR) begin
                    n_cls = CLS_CLEAR;
                end else begin
                    n_cls = CLS_REJECT;
                end
                n_x    = i_cmd.key ^ (i_cmd.key >> 33);
                n_step = 2'd0;
                n_pass = 1'b0;
            end
            F_MUL: begin
                if (r_step == 2'd0) begin
                    n_acc  = prod;
                    n_step = 2'd1;
                end else if (r_step == 2'd1) begin
                    n_acc  = mix;
                    n_step = 2'd2;
                end else if (!r_pass) begin
                    n_x    = mix ^ (mix >> 29);
                    n_pass = 1'b1;
                    n_step = 2'd0;
                end else begin
                    n_hash = mix[31:0] ^ mix[63:32];
                    n_home = n_hash[SLOT_W-1:0];
                    n_step = 2'd0;
                end
            end
            F_MOD: begin
                // Quotient from a reciprocal multiply is at most one short,
                // so a single compare and subtract finishes the remainder.
                if (r_step == 2'd0) begin
                    n_q    = 32'(q_prod >> (32 + SLOT_W));
                    n_step = 2'd1;
                end else begin
                    n_home = (rem_raw >= 33'(TABLE_SLOTS))
                             ? SLOT_W'(rem_raw - 33'(TABLE_SLOTS)) : SLOT_W'(rem_raw);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_cls  <= n_cls;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_step <= n_step;
        r_pass <= n_pass;
        r_hash <= n_hash;
        r_q    <= n_q;
        r_home <= n_home;
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_q_full;
    assign o_cmd  = r_cmd;
    assign o_cls  = r_cls;
    assign o_home = r_home;

endmodule

FILE: hdl/pkht_back.sv
module pkht_back
    import pkht_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096,
    parameter int SLOT_W      = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_cmd              i_cmd,
    input  t_cls              i_cls,
    input  logic [SLOT_W-1:0] i_home,
    output logic              o_pop,
    output logic              o_init,
    output logic              o_done,
    output t_res              o_res
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    t_bstate            r_state, n_state;
    t_cmd               r_cmd;
    logic [SLOT_W-1:0]  r_addr, n_addr;
    logic [SLOT_W-1:0]  r_i, n_i;
    logic [SLOT_W-1:0]  r_tomb, n_tomb;
    logic               r_tomb_v, n_tomb_v;
    logic [COUNT_W-1:0] r_live, n_live;
    logic [COUNT_W-1:0] r_used, n_used;
    logic               r_done, n_done;
    t_res               r_res, n_res;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    t_slot             wdata;
    t_slot             rd;
    logic [SLOT_W-1:0] next_addr;
    logic              hit, is_empty, is_tomb, last, in_range, addr_last;

    pkht_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rd)
    );

    assign o_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign next_addr = (r_addr == LAST_SLOT) ? '0 : r_addr + SLOT_W'(1);
    assign hit       = (rd.mark == MARK_LIVE) && (rd.key == r_cmd.key);
    assign is_empty  = (rd.mark == MARK_EMPTY);
    assign is_tomb   = (rd.mark == MARK_TOMB);
    assign last      = (r_i == LAST_SLOT);
    assign addr_last = (r_addr == LAST_SLOT);
    assign in_range  = (rd.mark == MARK_LIVE) && (rd.key >= r_cmd.key)
                       && (rd.key < r_cmd.key_end);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: if (addr_last) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cls)
                        CLS_HASH:  n_state = B_PRD;
                        CLS_RANGE: n_state = B_SRD;
                        CLS_CLEAR: n_state = B_CLR;
                        default:   n_state = B_IDLE;
                    endcase
                end
            end
            B_PRD: n_state = B_PEV;
            B_PEV: begin
                if (hit || is_empty || last) begin
                    n_state = B_IDLE;
                end else begin
                    n_state = B_PRD;
                end
            end
            B_SRD: n_state = B_SEV;
            B_SEV: n_state = addr_last ? B_IDLE : B_SRD;
            B_CLR: if (addr_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_addr   = r_addr;
        n_i      = r_i;
        n_tomb   = r_tomb;
        n_tomb_v = r_tomb_v;
        n_live   = r_live;
        n_used   = r_used;
        n_done   = 1'b0;
        n_res    = r_res;
        we       = 1'b0;
        waddr    = r_addr;
        wdata    = '{mark: MARK_LIVE, key: r_cmd.key, value: r_cmd.value_in};
        n_res.status    = ST_OK;
        n_res.value_out = '0;
        unique case (r_state)
            B_INIT, B_CLR: begin
                we     = 1'b1;
                wdata  = '{mark: MARK_EMPTY, key: r_cmd.key, value: r_cmd.value_in};
                n_addr = next_addr;
                if (addr_last) begin
                    n_live = '0;
                    n_used = '0;
                    n_done = (r_state == B_CLR);
                end
            end
            B_IDLE: begin
                n_addr   = (i_cls == CLS_HASH) ? i_home : '0;
                n_i      = '0;
                n_tomb_v = 1'b0;
                if (!i_q_empty && (i_cls == CLS_REJECT)) begin
                    n_done       = 1'b1;
                    n_res.status = ST_REJECT;
                end
            end
            B_PEV: begin
                if (r_cmd.op == OP_INSERT) begin
                    if (hit) begin
                        we     = 1'b1;
                        n_done = 1'b1;
                    end else if (is_empty) begin
                        we     = 1'b1;
                        waddr  = r_tomb_v ? r_tomb : r_addr;
                        n_used = r_tomb_v ? r_used : r_used + COUNT_W'(1);
                        n_live = r_live + COUNT_W'(1);
                        n_done = 1'b1;
                    end else begin
                        if (is_tomb && !r_tomb_v) begin
                            n_tomb   = r_addr;
                            n_tomb_v = 1'b1;
                        end
                        if (last) begin
                            n_done = 1'b1;
                            if (n_tomb_v) begin
                                we     = 1'b1;
                                waddr  = n_tomb;
                                n_live = r_live + COUNT_W'(1);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                    end
                end else begin
                    if (hit) begin
                        n_done = 1'b1;
                        if (r_cmd.op == OP_LOOKUP) begin
                            n_res.value_out = rd.value;
                        end else begin
                            we     = 1'b1;
                            wdata  = '{mark: MARK_TOMB, key: rd.key, value: rd.value};
                            n_live = r_live - COUNT_W'(1);
                        end
                    end else if (is_empty || last) begin
                        n_done       = 1'b1;
                        n_res.status = ST_MISS;
                    end
                end
                n_addr = next_addr;
                n_i    = r_i + SLOT_W'(1);
            end
            B_SEV: begin
                if (in_range) begin
                    we     = 1'b1;
                    wdata  = '{mark: MARK_TOMB, key: rd.key, value: rd.value};
                    n_live = r_live - COUNT_W'(1);
                end
                n_addr = next_addr;
                n_done = addr_last;
            end
            default: begin
            end
        endcase
        n_res.live_entries = n_live;
        n_res.used_slots   = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_addr  <= '0;
            r_live  <= '0;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_live  <= n_live;
            r_used  <= n_used;
            r_done  <= n_done;
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_i      <= n_i;
        r_tomb   <= n_tomb;
        r_tomb_v <= n_tomb_v;
        if (n_done) begin
            r_res <= n_res;
        end
    end

    assign o_init = (r_state == B_INIT);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_no_done_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_init |-> !r_done)
        else $error("result during the clearing pass");
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == B_INIT || r_state == B_CLR || r_state == B_PEV
                || r_state == B_SEV))
        else $error("table write outside a probe, scan or clear");
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.status != ST_OK) |-> (r_res.value_out == '0))
        else $error("value on a failed operation");
    a_no_pop_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_init |-> !o_pop)
        else $error("job taken during the clearing pass");

endmodule

FILE: hdl/pointer_keyed_hash_table_top.sv
// Channel   Handshake                   Payload
// command   start in, busy out          i_cmd  (op, key, key_end, value_in)
// result    o_done strobe, one cycle    o_res  (status, value_out, live_entries, used_slots)
//
// A command is taken when start is high and busy is low. The front end
// hashes a key with two 64-bit multiplies (three 32x32 partials each),
// adds a modulo step when TABLE_SLOTS is not a power of two, and passes
// any other command straight on; a full queue holds it in its push state.
// The back end reads and then evaluates each probed slot, reads and
// evaluates every slot for a range forget and writes every slot for a clear.
// After reset, busy stays high during a clearing pass over every slot.
// Results cannot be held off; each beat is valid for one cycle only.
module pointer_keyed_hash_table_top
    import pkht_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic              front_busy, back_init;
    logic              push, pop, q_full, q_empty;
    t_cmd              f_cmd, q_cmd;
    t_cls              f_cls, q_cls;
    logic [SLOT_W-1:0] f_home, q_home;

    assign busy = front_busy || back_init;

    pkht_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !back_init),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_busy   (front_busy),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_cls    (f_cls),
        .o_home   (f_home)
    );

    pkht_fifo #(
        .SLOT_W (SLOT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_cls   (f_cls),
        .i_home  (f_home),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd),
        .o_cls   (q_cls),
        .o_home  (q_home)
    );

    pkht_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .i_cls     (q_cls),
        .i_home    (q_home),
        .o_pop     (pop),
        .o_init    (back_init),
        .o_done    (o_done),
        .o_res     (o_res)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pkht_pkg::*;

    localparam int SLOTS      = 4096;
    localparam int IDLE_LIMIT = 200000;
    localparam int N_RANDOM   = 1150;

    typedef struct {
        t_cmd cmd;
        bit   drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd i_cmd = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    pointer_keyed_hash_table_top #(.TABLE_SLOTS(SLOTS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // Shadow copy of the table.
    logic [1:0]       shadow_mark  [SLOTS];
    logic [KEY_W-1:0] shadow_key   [SLOTS];
    logic [VAL_W-1:0] shadow_value [SLOTS];
    int               shadow_live;
    int               shadow_used;

    t_pending   cmd_queue[$];
    t_res       expected_res[$];
    logic [63:0] key_pool[64];
    int  errors;
    int  gap;
    int  burst_left;
    int  accepted;
    int  results_seen;
    int  status_hits[4];
    int  op_hits[8];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int home_of(logic [63:0] k);
        logic [63:0] x;
        x = k;
        x = x ^ (x >> 33);
        x = x * MIX_C1;
        x = x ^ (x >> 29);
        x = x * MIX_C2;
        x = x ^ (x >> 32);
        return int'(x[31:0] % SLOTS);
    endfunction

    // Index of the live slot that holds k, or SLOTS when it is absent.
    function automatic int locate(logic [63:0] k);
        int base;
        int s;
        base = home_of(k);
        for (int i = 0; i < SLOTS; i++) begin
            s = (base + i) % SLOTS;
            if (shadow_mark[s] == MARK_LIVE && shadow_key[s] == k) return s;
            if (shadow_mark[s] == MARK_EMPTY) break;
        end
        return SLOTS;
    endfunction

    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        int   base;
        int   s;
        int   tomb;
        bit   placed;
        r = '0;
        r.status = ST_OK;
        if (c.op <= OP_FORGET && c.key <= 64'd1) begin
            r.status = ST_REJECT;
        end else if (c.op == OP_INSERT) begin
            base = home_of(c.key);
            tomb = SLOTS;
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                s = (base + i) % SLOTS;
                if (shadow_mark[s] == MARK_LIVE) begin
                    if (shadow_key[s] == c.key) begin
                        shadow_value[s] = c.value_in;
                        placed = 1'b1;
                        break;
                    end
                end else if (shadow_mark[s] == MARK_EMPTY) begin
                    if (tomb == SLOTS) begin
                        tomb = s;
                        shadow_used++;
                    end
                    break;
                end else if (tomb == SLOTS) begin
                    tomb = s;
                end
            end
            if (!placed) begin
                if (tomb == SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_mark[tomb]  = MARK_LIVE;
                    shadow_key[tomb]   = c.key;
                    shadow_value[tomb] = c.value_in;
                    shadow_live++;
                end
            end
        end else if (c.op == OP_LOOKUP) begin
            s = locate(c.key);
            if (s < SLOTS) r.value_out = shadow_value[s];
            else r.status = ST_MISS;
        end else if (c.op == OP_FORGET) begin
            s = locate(c.key);
            if (s < SLOTS) begin
                shadow_mark[s] = MARK_TOMB;
                shadow_live--;
            end else begin
                r.status = ST_MISS;
            end
        end else if (c.op == OP_RANGE) begin
            if (c.key == 64'd0 || c.key >= c.key_end) begin
                r.status = ST_REJECT;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_mark[i] == MARK_LIVE && shadow_key[i] >= c.key
                            && shadow_key[i] < c.key_end) begin
                        shadow_mark[i] = MARK_TOMB;
                        shadow_live--;
                    end
                end
            end
        end else if (c.op == OP_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
            shadow_live = 0;
            shadow_used = 0;
        end else begin
            r.status = ST_REJECT;
        end
        r.live_entries = shadow_live[COUNT_W-1:0];
        r.used_slots   = shadow_used[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic queue_cmd(logic [2:0] op, logic [63:0] k, logic [63:0] kend,
                             logic [15:0] v, bit drain = 1'b0);
        t_pending p;
        p.cmd.op       = op;
        p.cmd.key      = k;
        p.cmd.key_end  = kend;
        p.cmd.value_in = v;
        p.drain        = drain;
        cmd_queue.push_back(p);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return key_pool[$urandom_range(0, 63)];
        if (sel < 90) return rand64();
        if (sel < 95) return 64'($urandom_range(0, 1));
        return key_pool[$urandom_range(0, 63)] + 64'd1;
    endfunction

    // Driver: one beat per accepted command, with random gaps between them.
    always @(posedge i_clk) begin
        bit       can_send;
        int       next_gap;
        t_pending p;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap   <= 0;
        end else if (start && !busy) begin
            expected_res.push_back(apply_cmd(i_cmd));
            accepted++;
            op_hits[i_cmd.op]++;
            if (burst_left > 0) begin
                burst_left--;
                next_gap = 0;
            end else begin
                next_gap = $urandom_range(0, 19);
                if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 60);
            end
            can_send = cmd_queue.size() > 0 && !cmd_queue[0].drain;
            if (next_gap == 0 && can_send) begin
                p = cmd_queue.pop_front();
                i_cmd <= p.cmd;
            end else begin
                start <= 1'b0;
                gap   <= next_gap;
            end
        end else if (!start) begin
            can_send = cmd_queue.size() > 0
                       && (!cmd_queue[0].drain || expected_res.size() == 0);
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (can_send) begin
                p = cmd_queue.pop_front();
                start <= 1'b1;
                i_cmd <= p.cmd;
            end
        end
    end

    // Monitor: every result beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_res), 64'd0);
            end else begin
                want = expected_res.pop_front();
                status_hits[want.status]++;
                if (o_res.status !== want.status)
                    report_mismatch("status", 64'(o_res.status), 64'(want.status));
                if (o_res.value_out !== want.value_out)
                    report_mismatch("value_out", 64'(o_res.value_out), 64'(want.value_out));
                if (o_res.live_entries !== want.live_entries)
                    report_mismatch("live_entries", 64'(o_res.live_entries),
                                    64'(want.live_entries));
                if (o_res.used_slots !== want.used_slots)
                    report_mismatch("used_slots", 64'(o_res.used_slots),
                                    64'(want.used_slots));
            end
        end
    end

    // Watchdog on cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] a;
        logic [63:0] b;
        int          sel;
        errors = 0;
        burst_left = 0;
        accepted = 0;
        results_seen = 0;
        for (int i = 0; i < 4; i++) status_hits[i] = 0;
        for (int i = 0; i < 8; i++) op_hits[i] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_mark[i]  = MARK_EMPTY;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end
        shadow_live = 0;
        shadow_used = 0;
        for (int i = 0; i < 64; i++) begin
            key_pool[i] = rand64();
            if (key_pool[i] <= 64'd1) key_pool[i] = 64'd2 + i;
        end

        // Directed: basic operations, reserved keys, bad ranges, unknown codes.
        queue_cmd(OP_INSERT, 64'd2, 64'd0, 16'h0000);
        queue_cmd(OP_INSERT, '1, '1, 16'hffff);
        queue_cmd(OP_LOOKUP, '1, 64'd0, 16'h0000);
        queue_cmd(OP_INSERT, '1, 64'd0, 16'h5a5a);
        queue_cmd(OP_LOOKUP, '1, 64'd0, 16'hffff);
        queue_cmd(OP_LOOKUP, 64'd3, 64'd0, 16'h0000);
        queue_cmd(OP_FORGET, '1, 64'd0, 16'h0000);
        queue_cmd(OP_FORGET, '1, 64'd0, 16'h0000);
        queue_cmd(OP_INSERT, '1, 64'd0, 16'h1234);
        for (int op = 0; op < 3; op++) begin
            queue_cmd(3'(op), 64'd0, '1, 16'hffff);
            queue_cmd(3'(op), 64'd1, '1, 16'hffff);
        end
        queue_cmd(OP_RANGE, 64'd0, 64'd100, 16'h0000);
        queue_cmd(OP_RANGE, 64'd100, 64'd100, 16'h0000);
        queue_cmd(OP_RANGE, 64'd200, 64'd100, 16'h0000);
        queue_cmd(OP_RANGE, 64'd1, 64'd3, 16'h0000);
        queue_cmd(OP_RANGE, 64'd4, '1, 16'h0000);
        queue_cmd(3'd5, 64'd7, 64'd8, 16'h0001);
        queue_cmd(3'd6, 64'd7, 64'd8, 16'h0001);
        queue_cmd(3'd7, '1, '1, 16'hffff);
        queue_cmd(OP_CLEAR, 64'd9, 64'd9, 16'h0000);

        // Insert, look up, a forget that misses, overwrite and a new insert, then a clear that waits
        // until every earlier result is back.
        queue_cmd(OP_INSERT, 64'd9000, 64'd0, 16'h0abc);
        queue_cmd(OP_LOOKUP, 64'd9000, 64'd0, 16'h0000);
        queue_cmd(OP_FORGET, 64'd2, 64'd0, 16'h0000);
        queue_cmd(OP_INSERT, 64'd9000, 64'd0, 16'h0abc);
        queue_cmd(OP_LOOKUP, 64'd9000, 64'd0, 16'h0000);
        queue_cmd(OP_INSERT, 64'd9001, 64'd0, 16'h0def);
        queue_cmd(OP_CLEAR, 64'd0, 64'd0, 16'h0000, 1'b1);

        // Random: mostly hashed operations on a small key pool, few scans.
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 42) begin
                queue_cmd(OP_INSERT, pick_key(), rand64(), 16'($urandom), n % 200 == 199);
            end else if (sel < 68) begin
                queue_cmd(OP_LOOKUP, pick_key(), rand64(), 16'($urandom));
            end else if (sel < 92) begin
                queue_cmd(OP_FORGET, pick_key(), rand64(), 16'($urandom));
            end else if (sel < 94) begin
                a = key_pool[$urandom_range(0, 63)];
                b = key_pool[$urandom_range(0, 63)];
                if ($urandom_range(0, 3) != 0 && a > b) begin
                    queue_cmd(OP_RANGE, b, a, 16'($urandom));
                end else begin
                    queue_cmd(OP_RANGE, a, b, 16'($urandom));
                end
            end else if (sel < 95) begin
                queue_cmd(OP_CLEAR, rand64(), rand64(), 16'($urandom));
            end else if (sel < 97) begin
                queue_cmd(3'($urandom_range(5, 7)), rand64(), rand64(), 16'($urandom));
            end else begin
                queue_cmd(OP_INSERT, rand64(), rand64(), 16'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() > 0 || start || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d commands and %0d results with random gaps and bursts.",
                 accepted, results_seen);
        $display("Status counts: ok %0d, miss %0d, reject %0d, full %0d; scans %0d, clears %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 op_hits[OP_RANGE], op_hits[OP_CLEAR]);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
